// ----- hdl/zsw_pkg.sv -----
package zsw_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 32;
  localparam int BlkW  = 16;

  // zlib header: deflate, 32K window, no dictionary, fastest level
  localparam logic [ByteW-1:0] ZlibCmf = 8'h78;
  localparam logic [ByteW-1:0] ZlibFlg = 8'h01;

  // stored block length limit (16-bit LEN field)
  localparam logic [LenW-1:0] MaxBlockBytes = 32'd65535;

  // Adler-32 modulus
  localparam logic [BlkW:0] AdlerMod = 17'd65521;

  // one queued data byte and what must be emitted around it
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             sos;      // stream start: zlib header first
    logic             sob;      // block start: stored block header first
    logic             fin;      // BFINAL of that block header
    logic [BlkW-1:0]  blk_len;  // LEN of that block header
    logic             last;     // last byte: Adler trailer follows
  } zsw_entry_t;

endpackage

// ----- hdl/zsw_in_if.sv -----
interface zsw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ----- hdl/zsw_out_if.sv -----
interface zsw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_stream;

  modport source (output valid, output out_byte, output last_of_run, output end_of_stream,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input end_of_stream,
                output ready);
endinterface

// ----- hdl/zlib_stored_stream_wrapper.sv -----
// Channel   Dir  Payload                                   Transfer when
// in_ch     in   data_byte[7:0]                            valid && ready
// out_ch    out  out_byte[7:0], last_of_run, end_of_stream valid && ready
// cfg       in   cfg_wdata_i[31:0] (stream_length)         cfg_we_i
//
// One data byte is taken per cycle while the queue has room; the output side
// sends one byte per cycle while out_ch is ready, with 2 zlib header bytes at
// stream start, 5 stored header bytes at block start and 4 Adler-32 bytes at
// stream end. The single output byte sequencer sets the long-run rate.
// The queue of FIFO_DEPTH entries lets input run ahead during header bursts.
// Reset (rst_ni low, asynchronous) clears all control state; stream_length
// returns to 1. Either side may stall at any cycle without loss.
module zlib_stored_stream_wrapper #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  zsw_in_if.sink      in_ch,
  zsw_out_if.source   out_ch
);
  import zsw_pkg::*;

  // classified byte handed from front to back
  zsw_entry_t push_entry, head;
  logic       push, full, pop, empty;

  // Front: latch the length at stream start, track stream and block counts,
  // tag each byte with the headers and trailer it needs.
  zsw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_ch        (in_ch),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Queue: decouple input acceptance from header and trailer bursts.
  zsw_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  // Back: expand each entry into its output bytes, advance Adler-32 on data
  // bytes, drive the registered output stage.
  zsw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- hdl/zsw_front.sv -----
module zsw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  zsw_in_if.sink              in_ch,
  input  logic                full_i,
  output logic                push_o,
  output zsw_pkg::zsw_entry_t push_entry_o
);
  import zsw_pkg::*;

  logic [LenW-1:0] len_q;
  logic            started_q, started_d;
  logic [LenW-1:0] brem_q, brem_d;
  logic [BlkW-1:0] blkrem_q, blkrem_d;

  logic [LenW-1:0] len_eff, brem, blk32;
  logic [BlkW-1:0] blkrem, blk_cur;
  logic            sob, fin, last, accept;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    len_eff = (len_q == '0) ? LenW'(1) : len_q;
    brem    = started_q ? brem_q : len_eff;
    blkrem  = started_q ? blkrem_q : '0;
    sob     = (blkrem == '0);
    blk32   = (brem > MaxBlockBytes) ? MaxBlockBytes : brem;
    fin     = (blk32 == brem);
    blk_cur = sob ? blk32[BlkW-1:0] : blkrem;
    last    = (brem == LenW'(1));

    started_d = !last;
    brem_d    = brem - LenW'(1);
    blkrem_d  = last ? '0 : blk_cur - BlkW'(1);
  end

  always_comb begin
    push_o                 = accept;
    push_entry_o.data_byte = in_ch.data_byte;
    push_entry_o.sos       = !started_q;
    push_entry_o.sob       = sob;
    push_entry_o.fin       = fin;
    push_entry_o.blk_len   = blk32[BlkW-1:0];
    push_entry_o.last      = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LenW'(1);
      started_q <= 1'b0;
      brem_q    <= '0;
      blkrem_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (accept) begin
        started_q <= started_d;
        brem_q    <= brem_d;
        blkrem_q  <= blkrem_d;
      end
    end
  end

endmodule

// ----- hdl/zsw_fifo.sv -----
module zsw_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  zsw_pkg::zsw_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output zsw_pkg::zsw_entry_t head_o
);
  import zsw_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  zsw_entry_t      mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- hdl/zsw_back.sv -----
module zsw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  zsw_pkg::zsw_entry_t head_i,
  output logic                pop_o,
  zsw_out_if.source           out_ch
);
  import zsw_pkg::*;

  typedef enum logic [3:0] {
    PH_ZH0, PH_ZH1,
    PH_BH0, PH_BH1, PH_BH2, PH_BH3, PH_BH4,
    PH_DATA,
    PH_AD0, PH_AD1, PH_AD2, PH_AD3
  } phase_e;

  phase_e           phase_q, cur_ph, next_ph;
  logic             busy_q;
  logic             out_valid_q, out_last_q, out_eos_q;
  logic [ByteW-1:0] out_byte_q, cur_byte;
  logic [BlkW-1:0]  sum_low_q, sum_high_q, low_n, high_n;
  logic [BlkW:0]    s1, s2;
  logic             advance, emit, ent_done;

  assign advance = !out_valid_q || out_ch.ready;
  assign emit    = advance && !empty_i;

  always_comb begin
    if (busy_q) begin
      cur_ph = phase_q;
    end else if (head_i.sos) begin
      cur_ph = PH_ZH0;
    end else if (head_i.sob) begin
      cur_ph = PH_BH0;
    end else begin
      cur_ph = PH_DATA;
    end
  end

  always_comb begin
    ent_done = 1'b0;
    next_ph  = cur_ph;
    cur_byte = head_i.data_byte;
    case (cur_ph)
      PH_ZH0: begin
        cur_byte = ZlibCmf;
        next_ph  = PH_ZH1;
      end
      PH_ZH1: begin
        cur_byte = ZlibFlg;
        next_ph  = PH_BH0;
      end
      PH_BH0: begin
        cur_byte = {7'b0, head_i.fin};
        next_ph  = PH_BH1;
      end
      PH_BH1: begin
        cur_byte = head_i.blk_len[7:0];
        next_ph  = PH_BH2;
      end
      PH_BH2: begin
        cur_byte = head_i.blk_len[15:8];
        next_ph  = PH_BH3;
      end
      PH_BH3: begin
        cur_byte = ~head_i.blk_len[7:0];
        next_ph  = PH_BH4;
      end
      PH_BH4: begin
        cur_byte = ~head_i.blk_len[15:8];
        next_ph  = PH_DATA;
      end
      PH_DATA: begin
        cur_byte = head_i.data_byte;
        next_ph  = PH_AD0;
        ent_done = !head_i.last;
      end
      PH_AD0: begin
        cur_byte = sum_high_q[15:8];
        next_ph  = PH_AD1;
      end
      PH_AD1: begin
        cur_byte = sum_high_q[7:0];
        next_ph  = PH_AD2;
      end
      PH_AD2: begin
        cur_byte = sum_low_q[15:8];
        next_ph  = PH_AD3;
      end
      PH_AD3: begin
        cur_byte = sum_low_q[7:0];
        ent_done = 1'b1;
      end
      default: begin
        ent_done = 1'b1;
      end
    endcase
  end

  // Adler-32 step: both partial sums stay below twice the modulus
  always_comb begin
    s1     = {1'b0, sum_low_q} + {9'b0, head_i.data_byte};
    low_n  = (s1 >= AdlerMod) ? BlkW'(s1 - AdlerMod) : s1[BlkW-1:0];
    s2     = {1'b0, sum_high_q} + {1'b0, low_n};
    high_n = (s2 >= AdlerMod) ? BlkW'(s2 - AdlerMod) : s2[BlkW-1:0];
  end

  assign pop_o = emit && ent_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ZH0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_eos_q   <= 1'b0;
      out_byte_q  <= '0;
      sum_low_q   <= BlkW'(1);
      sum_high_q  <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= cur_byte;
        out_last_q  <= ent_done;
        out_eos_q   <= (cur_ph == PH_AD3);
        busy_q      <= !ent_done;
        phase_q     <= next_ph;
        if (cur_ph == PH_ZH0) begin
          sum_low_q  <= BlkW'(1);
          sum_high_q <= '0;
        end else if (cur_ph == PH_DATA) begin
          sum_low_q  <= low_n;
          sum_high_q <= high_n;
        end
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.out_byte      = out_byte_q;
  assign out_ch.last_of_run   = out_last_q;
  assign out_ch.end_of_stream = out_eos_q;

`ifndef NO_ASSERTIONS
  a_busy_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !empty_i)
    else $error("sequencer mid-entry with empty queue");
  a_sum_low_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sum_low_q} < AdlerMod)
    else $error("Adler low sum not reduced");
  a_sum_high_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sum_high_q} < AdlerMod)
    else $error("Adler high sum not reduced");
  a_eos_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_eos_q |-> out_last_q)
    else $error("end of stream without end of run");
`endif

endmodule

// ----- tb/tb_zlib_stored_stream_wrapper.sv -----
module tb_zlib_stored_stream_wrapper;
  import zsw_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the forced output hold-off below.
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned SettleCycles = 3;
  localparam int unsigned PhaseItems  = 64;

  // One expected byte of the zlib stream and its flags.
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_run;
    logic             end_of_stream;
  } zlib_byte_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LenW-1:0]  cfg_wdata;

  zsw_in_if  in_if ();
  zsw_out_if out_if ();

  zlib_stored_stream_wrapper i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  // Raw bytes waiting for the driver, and zlib bytes the block still owes.
  logic [ByteW-1:0] raw_bytes_pending[$];
  zlib_byte_t       zlib_bytes_due[$];

  // Shadow of the wrapper state, advanced once per accepted input byte.
  logic [LenW-1:0]  len_reg;
  logic [LenW-1:0]  bytes_left;
  logic [BlkW-1:0]  blk_left;
  logic [15:0]      adler_lo;
  logic [15:0]      adler_hi;
  logic             in_stream;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_out;
  int unsigned streams_seen;
  int unsigned mismatches;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned stall_asks;
  int unsigned stall_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  logic        in_taken;

  // Free-running clock, period 4.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void emit_byte(logic [ByteW-1:0] b, logic eos);
    zlib_byte_t r;
    r.out_byte      = b;
    r.last_of_run   = 1'b0;
    r.end_of_stream = eos;
    zlib_bytes_due.push_back(r);
  endfunction

  // Wrap one raw byte: zlib header at stream start, stored block header at
  // block start, the byte itself, and the big-endian Adler-32 at stream end.
  function automatic void wrap_byte(logic [ByteW-1:0] b);
    logic [LenW-1:0] blk;
    logic [BlkW-1:0] inv;
    logic [31:0]     lo_next;
    logic [31:0]     hi_next;
    zlib_byte_t      r;
    if (!in_stream) begin
      // latch the length here; zero counts as one byte
      bytes_left = (len_reg != '0) ? len_reg : 32'd1;
      adler_lo   = 16'd1;
      adler_hi   = 16'd0;
      blk_left   = '0;
      in_stream  = 1'b1;
      emit_byte(ZlibCmf, 1'b0);
      emit_byte(ZlibFlg, 1'b0);
    end
    if (blk_left == '0) begin
      blk = (bytes_left > MaxBlockBytes) ? MaxBlockBytes : bytes_left;
      inv = ~blk[BlkW-1:0];
      emit_byte({7'd0, blk == bytes_left}, 1'b0);
      emit_byte(blk[7:0], 1'b0);
      emit_byte(blk[15:8], 1'b0);
      emit_byte(inv[7:0], 1'b0);
      emit_byte(inv[15:8], 1'b0);
      blk_left = blk[BlkW-1:0];
    end
    emit_byte(b, 1'b0);
    lo_next    = (32'(adler_lo) + 32'(b)) % 32'(AdlerMod);
    hi_next    = (32'(adler_hi) + lo_next) % 32'(AdlerMod);
    adler_lo   = lo_next[15:0];
    adler_hi   = hi_next[15:0];
    blk_left   = blk_left - 16'd1;
    bytes_left = bytes_left - 32'd1;
    if (bytes_left == '0) begin
      emit_byte(adler_hi[15:8], 1'b0);
      emit_byte(adler_hi[7:0], 1'b0);
      emit_byte(adler_lo[15:8], 1'b0);
      emit_byte(adler_lo[7:0], 1'b1);
      in_stream = 1'b0;
      blk_left  = '0;
    end
    // flag the final byte this input caused
    r = zlib_bytes_due.pop_back();
    r.last_of_run = 1'b1;
    zlib_bytes_due.push_back(r);
  endfunction

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at output byte %0d: %s got 0x%0h want 0x%0h",
             n_out, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    zlib_byte_t want;
    in_taken = in_if.valid && in_if.ready;
    // predict first so a same-edge pass-through still finds its expectation
    if (rst_n && in_taken) begin
      wrap_byte(in_if.data_byte);
      n_accepted++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      n_out++;
      if (zlib_bytes_due.size() == 0) begin
        flag_mismatch("transfer with nothing expected, out_byte",
                      32'(out_if.out_byte), '0);
      end else begin
        want = zlib_bytes_due.pop_front();
        if (out_if.out_byte !== want.out_byte)
          flag_mismatch("out_byte", 32'(out_if.out_byte), 32'(want.out_byte));
        if (out_if.last_of_run !== want.last_of_run)
          flag_mismatch("last_of_run", 32'(out_if.last_of_run), 32'(want.last_of_run));
        if (out_if.end_of_stream !== want.end_of_stream)
          flag_mismatch("end_of_stream", 32'(out_if.end_of_stream),
                        32'(want.end_of_stream));
        if (want.end_of_stream) streams_seen++;
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("watchdog: no transfer for %0d cycles, %0d bytes still due",
                   quiet_cycles, zlib_bytes_due.size());
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver: change inputs at the falling edge
  // ---------------------------------------------------------------------------

  // Advance to the next raw byte once the current one has been transferred;
  // hold it otherwise. Idle at random between bytes.
  always @(negedge clk) begin
    if (!in_if.valid || in_taken) begin
      if (raw_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.data_byte <= raw_bytes_pending.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Stall at random; on request, hold ready low for a long stretch.
  always @(negedge clk) begin
    if (stall_asks != stall_seen) begin
      stall_seen = stall_asks;
      hold_left  = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_byte(logic [ByteW-1:0] b);
    raw_bytes_pending.push_back(b);
    n_queued++;
  endtask

  // Queue n bytes: mostly random, sometimes a run of all ones or all zeros.
  task automatic queue_bytes(int unsigned n);
    int unsigned fill;
    fill = $urandom_range(9);
    for (int unsigned k = 0; k < n; k++) begin
      if (fill == 0) queue_byte(8'hFF);
      else if (fill == 1) queue_byte(8'h00);
      else queue_byte(8'($urandom_range(255)));
    end
  endtask

  // Wait until every queued byte is transferred and every zlib byte is in.
  task automatic wait_idle();
    do @(negedge clk);
    while (!(n_accepted == n_queued && zlib_bytes_due.size() == 0));
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Pulse the write enable for one cycle; mirror the value in the shadow.
  task automatic write_len(logic [LenW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    len_reg = v;
  endtask

  // Mostly short streams, a zero length now and then, a few longer ones.
  function automatic logic [LenW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 70) return 32'($urandom_range(12, 1));
    if (r < 92) return 32'($urandom_range(40, 13));
    return 32'($urandom_range(90, 41));
  endfunction

  // Run random streams under one idle mix. Some streams pause mid-way until
  // the block drains and get a new length written then, which must only
  // apply to the following stream.
  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned     sent;
    int unsigned     eff;
    int unsigned     head;
    logic [LenW-1:0] cur;
    logic [LenW-1:0] nxt;
    sent = 0;
    wait_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    cur = pick_len();
    write_len(cur);
    while (sent < PhaseItems) begin
      eff = (cur == '0) ? 1 : int'(cur);
      if (eff > 1 && $urandom_range(4) == 0) begin
        head = $urandom_range(eff - 1, 1);
        queue_bytes(head);
        wait_idle();
        nxt = pick_len();
        write_len(nxt);
        queue_bytes(eff - head);
        cur = nxt;
      end else begin
        queue_bytes(eff);
        // otherwise rearm back to back with the same length
        if ($urandom_range(2) == 0) begin
          wait_idle();
          cur = pick_len();
          write_len(cur);
        end
      end
      sent += eff;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    in_taken        = 1'b0;
    len_reg         = 32'd1;
    bytes_left      = '0;
    blk_left        = '0;
    adler_lo        = 16'd1;
    adler_hi        = 16'd0;
    in_stream       = 1'b0;
    n_queued        = 0;
    n_accepted      = 0;
    n_out           = 0;
    streams_seen    = 0;
    mismatches      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    stall_asks      = 0;
    stall_seen      = 0;
    hold_left       = 0;
    quiet_cycles    = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Directed: reset length of one, zero length treated as one.
    queue_byte(8'h00);
    wait_idle();
    write_len(32'd0);
    queue_byte(8'hFF);
    wait_idle();

    // Directed: a length written mid-stream applies only to the next stream.
    write_len(32'd3);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    wait_idle();
    write_len(32'd5);
    queue_byte(8'h01);
    queue_byte(8'hAA);
    queue_byte(8'h55);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hFE);
    wait_idle();

    // Directed: streams back to back, the Adler sums restart at each one.
    write_len(32'd1);
    queue_byte(8'h12);
    queue_byte(8'h34);
    wait_idle();
    write_len(32'd2);
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'h01);
    queue_byte(8'h80);
    wait_idle();

    // Pressure: keep offering while the receiver holds off, so the block
    // fills up and stalls its input.
    write_len(32'd40);
    queue_bytes(40);
    stall_asks++;
    wait_idle();

    // Random phases, one per idle mix.
    run_phase(0, 0);
    run_phase(84, 0);
    run_phase(0, 84);
    run_phase(27, 27);

    // Largest length: start a stream that cannot finish, write a new
    // length in the middle of it, and stop there.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_len(32'hFFFF_FFFF);
    queue_bytes(20);
    wait_idle();
    write_len(32'd7);
    queue_bytes(5);
    wait_idle();

    // Let any stray output show up before the verdict.
    repeat (20) @(negedge clk);

    $display("Run covered %0d finished streams: %0d raw bytes in, %0d zlib bytes out.",
             streams_seen, n_accepted, n_out);
    $display("Lengths 0 to 2^32-1 with a non-final first block, mid-stream writes, four idle mixes.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/zsw_pkg.sv
hdl/zsw_in_if.sv
hdl/zsw_out_if.sv
hdl/zsw_front.sv
hdl/zsw_fifo.sv
hdl/zsw_back.sv
hdl/zlib_stored_stream_wrapper.sv
tb/tb_zlib_stored_stream_wrapper.sv
